// ===== src/glcw_pkg.sv =====
// Shared types and defaults for the grid line cell walker.
`timescale 1ns / 1ps
`default_nettype none

package glcw_pkg;

    // Default coordinate width (32 by 32 grid)
    localparam int COORD_BITS_DEF = 5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } glcw_state_t;

    // Decision of one walk step, from the step unit to the sequencer
    typedef struct packed {
        logic move_x;
        logic move_y;
        logic escape;
    } glcw_move_t;

endpackage

`default_nettype wire

// ===== src/glcw_stepper.sv =====
// Shared compare and advance unit: decides one move of the line walk.
`timescale 1ns / 1ps
`default_nettype none

module glcw_stepper
    import glcw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int ErrBits = 2 * COORD_BITS + 2
)
(
    input  wire logic [COORD_BITS-1:0]   cur_x,
    input  wire logic [COORD_BITS-1:0]   cur_y,
    input  wire logic                    step_left,
    input  wire logic signed [COORD_BITS:0] delta_x,
    input  wire logic signed [COORD_BITS:0] delta_y,
    input  wire logic signed [ErrBits-1:0] err_y,
    input  wire logic signed [ErrBits-1:0] err_x,
    output glcw_move_t                   move,
    output logic signed [ErrBits-1:0]    err_y_next,
    output logic signed [ErrBits-1:0]    err_x_next
);

    localparam logic [COORD_BITS-1:0] CoordMax = {COORD_BITS{1'b1}};

    logic signed [ErrBits-1:0] mag_y;
    logic signed [ErrBits-1:0] mag_x;
    logic signed [ErrBits-1:0] dx_ext;
    logic signed [ErrBits-1:0] dy_ext;
    logic                      x_wrap;
    logic                      y_wrap;

    // Widen the deltas to the error width
    assign dx_ext = {{(ErrBits-COORD_BITS-1){delta_x[COORD_BITS]}}, delta_x};
    assign dy_ext = {{(ErrBits-COORD_BITS-1){delta_y[COORD_BITS]}}, delta_y};

    // Compare magnitudes of the two cross products
    assign mag_y = err_y[ErrBits-1] ? -err_y : err_y;
    assign mag_x = err_x[ErrBits-1] ? -err_x : err_x;

    assign move.move_x = (mag_y >= mag_x);
    assign move.move_y = (mag_y <= mag_x);

    // Flag a move that would leave the grid
    assign x_wrap = step_left ? (cur_x == '0) : (cur_x == CoordMax);
    assign y_wrap = (cur_y == '0);
    assign move.escape = (move.move_x && x_wrap) || (move.move_y && y_wrap);

    // Advance the running products with the move
    assign err_y_next = move.move_y ? (err_y - dx_ext) : err_y;
    assign err_x_next = move.move_x ? (step_left ? (err_x - dy_ext) : (err_x + dy_ext))
                                    : err_x;

endmodule

`default_nettype wire

// ===== src/grid_line_cell_walker.sv =====
// Top level: line request sequencer that emits every grid cell a line crosses.
// The request beat loads the walk registers; the first cell comes from the walk state
// through the output registers. Throughput: one cell per cycle; a request is taken only
// in idle, so a new line waits for the last to end, at most 63 cells on a 32 by 32 grid.
// The rate is set by the single compare and advance unit, which makes one move a cycle.
// Reset (rst_n low, asynchronous) returns to idle with no strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module grid_line_cell_walker
    import glcw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    input  wire logic [7:0]            line_symbol,
    output logic                       strobe,
    output logic [COORD_BITS-1:0]      cell_x,
    output logic [COORD_BITS-1:0]      cell_y,
    output logic [7:0]                 cell_symbol,
    output logic                       last_cell
);

    localparam int ErrBits = 2 * COORD_BITS + 2;
    localparam int MaxCells = (2 << COORD_BITS) - 1;
    localparam logic [COORD_BITS:0] CountCap = (COORD_BITS+1)'(MaxCells - 1);

    glcw_state_t state_reg, state_next;

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      goal_x_reg, goal_x_next;
    logic [COORD_BITS-1:0]      goal_y_reg, goal_y_next;
    logic signed [COORD_BITS:0] dx_reg, dx_next;
    logic signed [COORD_BITS:0] dy_reg, dy_next;
    logic                       step_left_reg, step_left_next;
    logic signed [ErrBits-1:0]  err_y_reg, err_y_next;
    logic signed [ErrBits-1:0]  err_x_reg, err_x_next;
    logic [COORD_BITS:0]        count_reg, count_next;
    logic [7:0]                 sym_reg, sym_next;

    logic                       strobe_reg, strobe_next;
    logic                       last_reg, last_next;
    logic [COORD_BITS-1:0]      out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]      out_y_reg, out_y_next;
    logic [7:0]                 out_sym_reg, out_sym_next;

    glcw_move_t                 move;
    logic signed [ErrBits-1:0]  step_err_y;
    logic signed [ErrBits-1:0]  step_err_x;

    // Ordered endpoints of an incoming request
    logic                       swap;
    logic [COORD_BITS-1:0]      org_x, org_y, tgt_x, tgt_y;
    logic signed [COORD_BITS:0] req_dx, req_dy;
    logic                       req_left;
    logic signed [ErrBits-1:0]  req_dx_ext, req_dy_ext;
    logic                       at_goal;

    assign swap   = (start_y < end_y);
    assign org_x  = swap ? end_x : start_x;
    assign org_y  = swap ? end_y : start_y;
    assign tgt_x  = swap ? start_x : end_x;
    assign tgt_y  = swap ? start_y : end_y;
    assign req_left = !(org_x < tgt_x);
    assign req_dx = {1'b0, tgt_x} - {1'b0, org_x};
    assign req_dy = {1'b0, tgt_y} - {1'b0, org_y};
    assign req_dx_ext = {{(ErrBits-COORD_BITS-1){req_dx[COORD_BITS]}}, req_dx};
    assign req_dy_ext = {{(ErrBits-COORD_BITS-1){req_dy[COORD_BITS]}}, req_dy};

    assign at_goal = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    // Shared compare and advance unit
    glcw_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .cur_x      (cur_x_reg),
        .cur_y      (cur_y_reg),
        .step_left  (step_left_reg),
        .delta_x    (dx_reg),
        .delta_y    (dy_reg),
        .err_y      (err_y_reg),
        .err_x      (err_x_reg),
        .move       (move),
        .err_y_next (step_err_y),
        .err_x_next (step_err_x)
    );

    // Hold state and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            strobe_reg    <= 1'b0;
            last_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            step_left_reg <= 1'b0;
            err_y_reg     <= '0;
            err_x_reg     <= '0;
            count_reg     <= '0;
            sym_reg       <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_sym_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            last_reg      <= last_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            step_left_reg <= step_left_next;
            err_y_reg     <= err_y_next;
            err_x_reg     <= err_x_next;
            count_reg     <= count_next;
            sym_reg       <= sym_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_sym_reg   <= out_sym_next;
        end
    end

    // Sequence the walk: load, step one cell a cycle, finish on the goal, the cap or a grid exit
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        step_left_next = step_left_reg;
        err_y_next     = err_y_reg;
        err_x_next     = err_x_reg;
        count_next     = count_reg;
        sym_next       = sym_reg;
        strobe_next    = 1'b0;
        last_next      = 1'b0;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_sym_next   = out_sym_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_x_next     = org_x;
                    cur_y_next     = org_y;
                    goal_x_next    = tgt_x;
                    goal_y_next    = tgt_y;
                    dx_next        = req_dx;
                    dy_next        = req_dy;
                    step_left_next = req_left;
                    err_y_next     = -req_dx_ext;
                    err_x_next     = req_left ? -req_dy_ext : req_dy_ext;
                    count_next     = '0;
                    sym_next       = line_symbol;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                strobe_next  = 1'b1;
                out_sym_next = sym_reg;
                if (!at_goal && (count_reg < CountCap))
                begin
                    // Emit the current cell and advance, or close if the move would leave the grid
                    out_x_next = cur_x_reg;
                    out_y_next = cur_y_reg;
                    count_next = count_reg + 1'b1;
                    if (move.escape)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        if (move.move_x)
                        begin
                            cur_x_next = step_left_reg ? (cur_x_reg - 1'b1)
                                                       : (cur_x_reg + 1'b1);
                        end
                        if (move.move_y)
                        begin
                            cur_y_next = cur_y_reg - 1'b1;
                        end
                        err_y_next = step_err_y;
                        err_x_next = step_err_x;
                    end
                end
                else
                begin
                    out_x_next = goal_x_reg;
                    out_y_next = goal_y_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                // Walk left the grid: close with the end cell
                strobe_next  = 1'b1;
                out_sym_next = sym_reg;
                out_x_next   = goal_x_reg;
                out_y_next   = goal_y_reg;
                last_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign last_cell   = last_reg;
    assign cell_x      = out_x_reg;
    assign cell_y      = out_y_reg;
    assign cell_symbol = out_sym_reg;

    // The end cell beat is shown only once the sequencer is back in idle
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_cell) |-> !busy)
        else $error("last cell shown while still walking");

    // An accepted request starts a walk with no beat in the first cycle
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("request accept did not start a walk");

    // Every beat comes from a cycle in which the walk was active
    a_beat_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("cell beat without an active walk");

endmodule

`default_nettype wire
